@@ hw/rtl/abdsh_pkg.sv @@
// shared constants, state codes and control structs of the drop shadow blur
package abdsh_pkg;

  // default sizing of the frame store
  localparam int DEF_MAX_SOURCE_WIDTH  = 256;
  localparam int DEF_MAX_SOURCE_HEIGHT = 256;
  localparam int DEF_MAX_SHADOW        = 32;

  // field widths
  localparam int OPCODE_W   = 1;
  localparam int ALPHA_W    = 8;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int GAIN_W     = 17;

  // fixed point of the gain
  localparam int GAIN_ONE   = 65536;
  localparam int GAIN_SHIFT = 16;
  localparam int ALPHA_MAX  = 255;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHADOW_SIZE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 2'd3;

  // controller states
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
  localparam logic [ST_W-1:0] ST_LSTART = 3'd2;
  localparam logic [ST_W-1:0] ST_RUN    = 3'd3;
  localparam logic [ST_W-1:0] ST_DRAIN  = 3'd4;
  localparam logic [ST_W-1:0] ST_READY  = 3'd5;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic load;
    logic rd_frame;
    logic rd_nr;
    logic row_start;
    logic col_start;
    logic line_start;
    logic issue;
    logic next_line;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic load_last;
    logic rd_last;
    logic pos_last;
    logic line_last;
    logic pass_col;
    logic out_busy;
  } stat_t;

endpackage

@@ hw/rtl/abdsh_ctrl.sv @@
// controller state machine of the drop shadow blur
module abdsh_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           in_valid,
  input  logic [abdsh_pkg::OPCODE_W-1:0] in_opcode,
  input  abdsh_pkg::stat_t               stat,
  output logic                           in_ready,
  output abdsh_pkg::cmd_t                cmd
);

  logic [abdsh_pkg::ST_W-1:0] state_r, state_nxt;
  logic                       acc;

  assign acc = in_valid && in_ready;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = ((state_r == abdsh_pkg::ST_IDLE) || (state_r == abdsh_pkg::ST_READY)) &&
                !stat.out_busy;
    case (state_r)
      abdsh_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = abdsh_pkg::ST_IDLE;
      end
      abdsh_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_opcode == abdsh_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
            if (stat.load_last) begin
              cmd.row_start = 1'b1;
              state_nxt     = abdsh_pkg::ST_LSTART;
            end
          end else begin
            cmd.rd_nr = 1'b1;
          end
        end
      end
      abdsh_pkg::ST_LSTART: begin
        cmd.line_start = 1'b1;
        state_nxt      = abdsh_pkg::ST_RUN;
      end
      abdsh_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
        if (stat.pos_last) state_nxt = abdsh_pkg::ST_DRAIN;
      end
      abdsh_pkg::ST_DRAIN: begin
        state_nxt = abdsh_pkg::ST_LSTART;
        if (stat.line_last) begin
          if (stat.pass_col) state_nxt = abdsh_pkg::ST_READY;
          else cmd.col_start = 1'b1;
        end else begin
          cmd.next_line = 1'b1;
        end
      end
      abdsh_pkg::ST_READY: begin
        // loads after the frame is complete are dropped
        if (acc && (in_opcode == abdsh_pkg::OP_READ)) begin
          cmd.rd_frame = 1'b1;
          if (stat.rd_last) begin
            cmd.clr_start = 1'b1;
            state_nxt     = abdsh_pkg::ST_CLEAR;
          end
        end
      end
      default: state_nxt = abdsh_pkg::ST_CLEAR;
    endcase
    // register write restarts the frame
    if (cfg_we) begin
      cmd.clr_start = 1'b1;
      state_nxt     = abdsh_pkg::ST_CLEAR;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= abdsh_pkg::ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // checks
  a_last_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_frame && stat.rd_last) |=> (state_r == abdsh_pkg::ST_CLEAR))
    else $error("final read did not start the clearing pass");

  a_last_load_blurs: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && stat.load_last && !cfg_we) |=> (state_r == abdsh_pkg::ST_LSTART))
    else $error("final load did not start the blur");

  a_accept_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> !stat.out_busy)
    else $error("word accepted while result stage busy");

  a_ready_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == abdsh_pkg::ST_READY) |->
      ($past(state_r) == abdsh_pkg::ST_READY) || ($past(state_r) == abdsh_pkg::ST_DRAIN))
    else $error("frame ready without finishing the column pass");

endmodule

@@ hw/rtl/abdsh_dp.sv @@
// datapath of the drop shadow blur: registers, frame store, box sum and output stage
module abdsh_dp #(
  parameter int MAX_SOURCE_WIDTH  = abdsh_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = abdsh_pkg::DEF_MAX_SOURCE_HEIGHT,
  parameter int MAX_SHADOW        = abdsh_pkg::DEF_MAX_SHADOW
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [abdsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abdsh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [abdsh_pkg::ALPHA_W-1:0]    in_alpha,
  input  abdsh_pkg::cmd_t                  cmd,
  output abdsh_pkg::stat_t                 stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [abdsh_pkg::ALPHA_W-1:0]    out_shadow_alpha,
  output logic                             out_last_pixel,
  output logic                             out_status
);

  localparam int WW      = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int HW      = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int SW      = $clog2(MAX_SHADOW + 1);
  localparam int PAD_WM  = MAX_SOURCE_WIDTH + 2 * MAX_SHADOW;
  localparam int PAD_HM  = MAX_SOURCE_HEIGHT + 2 * MAX_SHADOW;
  localparam int LW      = $clog2(((PAD_WM > PAD_HM) ? PAD_WM : PAD_HM) + 1);
  localparam int DEPTH   = PAD_WM * PAD_HM;
  localparam int AW      = $clog2(DEPTH);
  localparam int TW      = $clog2(DEPTH + 1);
  localparam int SUMW    = $clog2(MAX_SHADOW * abdsh_pkg::ALPHA_MAX + 1);
  localparam int HIW     = (MAX_SHADOW > 1) ? $clog2(MAX_SHADOW) : 1;
  localparam int PRW     = SUMW + abdsh_pkg::GAIN_W;
  localparam int GW      = abdsh_pkg::GAIN_W;
  localparam int AL      = abdsh_pkg::ALPHA_W;

  // configuration registers
  logic [WW-1:0] w_r;
  logic [HW-1:0] h_r;
  logic [SW-1:0] s_r;
  logic [GW-1:0] gain_r;
  logic [WW-1:0] w_sat;
  logic [HW-1:0] h_sat;
  logic [SW-1:0] s_sat;
  logic [GW-1:0] gain_sat;

  // derived geometry
  logic [LW-1:0] pw_c, ph_c, pw_r, ph_r;
  logic [TW-1:0] total_r;
  logic [AW-1:0] ldstart_r;
  logic [SW-1:0] left_c, right_c;

  // counters
  logic [TW-1:0] cc_r, rc_r;
  logic [WW-1:0] sx_r;
  logic [HW-1:0] sy_r;
  logic [AW-1:0] ld_addr_r;

  // blur state
  logic          pass_r;
  logic [LW-1:0] line_r, pos_r, dq_r;
  logic [AW-1:0] base_r, rd_addr_r, wp_r;
  logic          dv_r;
  logic [SUMW-1:0] sum_r;
  logic [AL-1:0] hist_r [MAX_SHADOW];
  logic [HIW-1:0] idx_r;
  logic [LW-1:0] len_c, nlines_c;
  logic [AW-1:0] stride_c;
  logic          main_c;

  // frame store
  logic [AL-1:0] mem [DEPTH];
  logic [AL-1:0] mem_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [AL-1:0] wdata;

  // scaling
  logic [PRW-1:0] prod_c, shr_c;
  logic [AL-1:0]  scaled_c;

  // output stage
  logic          pend_r, pend_nr_r, pend_last_r;
  logic          out_valid_r;
  logic [AL-1:0] out_alpha_r;
  logic          out_last_r, out_status_r;

  // saturate register writes into range
  always_comb begin
    if (cfg_data == '0) w_sat = WW'(1);
    else if (32'(cfg_data) > MAX_SOURCE_WIDTH) w_sat = WW'(MAX_SOURCE_WIDTH);
    else w_sat = WW'(cfg_data);
    if (cfg_data == '0) h_sat = HW'(1);
    else if (32'(cfg_data) > MAX_SOURCE_HEIGHT) h_sat = HW'(MAX_SOURCE_HEIGHT);
    else h_sat = HW'(cfg_data);
    if (cfg_data == '0) s_sat = SW'(1);
    else if (32'(cfg_data) > MAX_SHADOW) s_sat = SW'(MAX_SHADOW);
    else s_sat = SW'(cfg_data);
    if (32'(cfg_data) > abdsh_pkg::GAIN_ONE) gain_sat = GW'(abdsh_pkg::GAIN_ONE);
    else gain_sat = GW'(cfg_data);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= WW'(1);
      h_r    <= HW'(1);
      s_r    <= SW'(1);
      gain_r <= GW'(abdsh_pkg::GAIN_ONE);
    end else if (cfg_we) begin
      case (cfg_index)
        abdsh_pkg::REG_SOURCE_WIDTH:  w_r    <= w_sat;
        abdsh_pkg::REG_SOURCE_HEIGHT: h_r    <= h_sat;
        abdsh_pkg::REG_SHADOW_SIZE:   s_r    <= s_sat;
        abdsh_pkg::REG_GAIN:          gain_r <= gain_sat;
        default: ;
      endcase
    end
  end

  // padded geometry, registered from the configuration registers
  assign pw_c    = LW'(w_r) + (LW'(s_r) << 1);
  assign ph_c    = LW'(h_r) + (LW'(s_r) << 1);
  assign left_c  = SW'((s_r - SW'(1)) >> 1);
  assign right_c = s_r - left_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r      <= '0;
      ph_r      <= '0;
      total_r   <= '0;
      ldstart_r <= '0;
    end else begin
      pw_r      <= pw_c;
      ph_r      <= ph_c;
      total_r   <= TW'(TW'(pw_c) * TW'(ph_c));
      ldstart_r <= AW'(AW'(s_r) * AW'(pw_c) + AW'(s_r));
    end
  end

  // line geometry of the current pass
  assign len_c    = pass_r ? ph_r : pw_r;
  assign nlines_c = pass_r ? pw_r : ph_r;
  assign stride_c = pass_r ? AW'(pw_r) : AW'(1);
  assign main_c   = dv_r && (dq_r >= LW'(s_r));

  // status
  assign stat.clr_last  = (cc_r == total_r - TW'(1));
  assign stat.load_last = (sx_r == w_r - WW'(1)) && (sy_r == h_r - HW'(1));
  assign stat.rd_last   = (rc_r == total_r - TW'(1));
  assign stat.pos_last  = (pos_r == len_c - LW'(1));
  assign stat.line_last = (line_r == nlines_c - LW'(1));
  assign stat.pass_col  = pass_r;
  assign stat.out_busy  = out_valid_r | pend_r;

  // clear, load and read counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r      <= '0;
      rc_r      <= '0;
      sx_r      <= '0;
      sy_r      <= '0;
      ld_addr_r <= '0;
    end else begin
      if (cmd.clr_start) begin
        cc_r <= '0;
      end else if (cmd.clr_step) begin
        cc_r <= cc_r + TW'(1);
        if (stat.clr_last) begin
          sx_r      <= '0;
          sy_r      <= '0;
          ld_addr_r <= ldstart_r;
          rc_r      <= '0;
        end
      end
      if (cmd.load) begin
        if (sx_r == w_r - WW'(1)) begin
          sx_r      <= '0;
          sy_r      <= sy_r + HW'(1);
          ld_addr_r <= ld_addr_r + AW'(1) + (AW'(s_r) << 1);
        end else begin
          sx_r      <= sx_r + WW'(1);
          ld_addr_r <= ld_addr_r + AW'(1);
        end
      end
      if (cmd.rd_frame) rc_r <= rc_r + TW'(1);
    end
  end

  // line sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
      line_r <= '0;
      base_r <= '0;
      pos_r  <= '0;
      dv_r   <= 1'b0;
    end else begin
      dv_r <= cmd.issue;
      if (cmd.row_start) begin
        pass_r <= 1'b0;
        line_r <= '0;
        base_r <= '0;
      end else if (cmd.col_start) begin
        pass_r <= 1'b1;
        line_r <= '0;
        base_r <= '0;
      end else if (cmd.next_line) begin
        line_r <= line_r + LW'(1);
        base_r <= base_r + (pass_r ? AW'(1) : AW'(pw_r));
      end
      if (cmd.line_start) pos_r <= '0;
      else if (cmd.issue) pos_r <= pos_r + LW'(1);
    end
  end

  // running box sum over the window history
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_addr_r <= rd_addr_r + stride_c;
      dq_r      <= pos_r;
    end
    if (dv_r) begin
      if (!main_c) begin
        sum_r                  <= sum_r + SUMW'(mem_q);
        hist_r[dq_r[HIW-1:0]]  <= mem_q;
      end else begin
        sum_r         <= sum_r - SUMW'(hist_r[idx_r]) + SUMW'(mem_q);
        hist_r[idx_r] <= mem_q;
        idx_r         <= (idx_r == HIW'(s_r - SW'(1))) ? '0 : idx_r + HIW'(1);
      end
      if (dq_r >= LW'(right_c)) wp_r <= wp_r + stride_c;
    end
    if (cmd.line_start) begin
      rd_addr_r <= base_r;
      wp_r      <= base_r;
      sum_r     <= '0;
      idx_r     <= '0;
    end
  end

  // gain and saturation
  assign prod_c   = PRW'(sum_r) * PRW'(gain_r);
  assign shr_c    = prod_c >> abdsh_pkg::GAIN_SHIFT;
  assign scaled_c = (shr_c > PRW'(abdsh_pkg::ALPHA_MAX)) ? AL'(abdsh_pkg::ALPHA_MAX)
                                                         : shr_c[AL-1:0];

  // frame store port selection
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = cc_r[AW-1:0];
    end else if (cmd.load) begin
      we    = 1'b1;
      waddr = ld_addr_r;
      wdata = in_alpha;
    end else if (main_c) begin
      we    = 1'b1;
      waddr = wp_r;
      wdata = scaled_c;
    end
  end
  assign raddr = cmd.issue ? rd_addr_r : rc_r[AW-1:0];

  // frame store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mem_q <= mem[raddr];
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= cmd.rd_frame | cmd.rd_nr;
      if (pend_r) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_frame | cmd.rd_nr) begin
      pend_nr_r   <= cmd.rd_nr;
      pend_last_r <= cmd.rd_frame & stat.rd_last;
    end
    if (pend_r) begin
      out_alpha_r  <= pend_nr_r ? '0 : mem_q;
      out_last_r   <= pend_last_r;
      out_status_r <= pend_nr_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_shadow_alpha = out_alpha_r;
  assign out_last_pixel   = out_last_r;
  assign out_status       = out_status_r;

endmodule

@@ hw/rtl/alpha_box_blur_drop_shadow.sv @@
// top level of the alpha drop shadow blur
//
// Input words carry an opcode and a source alpha byte. Loads (opcode 0) fill
// the source image in raster order into a frame store padded with a zero
// border of shadow_size pixels; one load is taken per cycle while no read
// result is pending. After the final load the block blurs the frame along
// rows, then columns, with a running box sum through the one read port and
// one write port of the store; pw and ph are the padded width and height.
// No word is taken during the blur.
// Reads (opcode 1) return the next blurred pixel with last_pixel on the final
// one, or status 1 when the frame is not finished. A result passes through
// a pending register into the output register, and the next word is taken
// once the result has left. A stalled result simply holds the input side off.
// After reset, a register write or the final read, a clearing pass zeroes
// pw*ph entries of the store, one per cycle, before the next word is taken.
// Register writes go through cfg_we, cfg_index and cfg_data with no wait.
module alpha_box_blur_drop_shadow #(
  parameter int MAX_SOURCE_WIDTH  = abdsh_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = abdsh_pkg::DEF_MAX_SOURCE_HEIGHT,
  parameter int MAX_SHADOW        = abdsh_pkg::DEF_MAX_SHADOW
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [abdsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abdsh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [abdsh_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [abdsh_pkg::ALPHA_W-1:0]    in_source_alpha,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [abdsh_pkg::ALPHA_W-1:0]    out_shadow_alpha,
  output logic                             out_last_pixel,
  output logic                             out_status
);

  abdsh_pkg::cmd_t  cmd;
  abdsh_pkg::stat_t stat;

  // sequencer
  abdsh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // store, blur and result stage
  abdsh_dp #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .MAX_SHADOW        (MAX_SHADOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_alpha         (in_source_alpha),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_shadow_alpha (out_shadow_alpha),
    .out_last_pixel   (out_last_pixel),
    .out_status       (out_status)
  );

endmodule
